/* rtl/rff_pkg.sv */
// shared types and constants for the rangefinder frame receiver
`default_nettype none

package rff_pkg;

	// frame layout
	localparam int FRAME_LEN_DEF = 8;
	localparam int CNT_W         = 5;
	localparam int STATUS_IDX    = 2;
	localparam int DIST_FIRST    = 3;
	localparam int DIST_LAST     = 6;

	// register defaults and map
	localparam logic [7:0] FIRST_HEADER_RST  = 8'hb4;
	localparam logic [7:0] SECOND_HEADER_RST = 8'h69;
	localparam int         PADDR_W           = 3;
	localparam logic       REG_FIRST_HEADER  = 1'b0;
	localparam logic       REG_SECOND_HEADER = 1'b1;

	// hunt phase of the frame parser
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	// header values from the register block
	typedef struct packed {
		logic [7:0] first_header;
		logic [7:0] second_header;
	} rff_cfg_t;

	// one checked frame, valid for a single cycle
	typedef struct packed {
		logic        valid;
		logic [31:0] distance_value;
		logic        fault_flag;
	} rff_result_t;

endpackage

`default_nettype wire

/* rtl/rff_cfg_regs.sv */
// header value registers behind the apb port
`default_nettype none

module rff_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rff_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output rff_pkg::rff_cfg_t                cfg
);
	import rff_pkg::*;

	logic [7:0] first_header_q;
	logic [7:0] second_header_q;
	logic       wr_en;
	logic       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_header_q  <= FIRST_HEADER_RST;
			second_header_q <= SECOND_HEADER_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FIRST_HEADER:  first_header_q  <= pwdata[7:0];
				REG_SECOND_HEADER: second_header_q <= pwdata[7:0];
				default:           ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_FIRST_HEADER:  prdata = {24'd0, first_header_q};
			REG_SECOND_HEADER: prdata = {24'd0, second_header_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.first_header  = first_header_q;
	assign cfg.second_header = second_header_q;

endmodule

`default_nettype wire

/* rtl/rff_parser.sv */
// header hunt, body capture and xor check of one frame
`default_nettype none

module rff_parser #(
	parameter int FRAME_LEN = rff_pkg::FRAME_LEN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_en,
	input  wire logic [7:0]           rx_byte,
	input  wire rff_pkg::rff_cfg_t    cfg,
	output rff_pkg::rff_result_t      result
);
	import rff_pkg::*;

	localparam logic [CNT_W-1:0] CheckIdx  = CNT_W'(FRAME_LEN - 1);
	localparam logic [CNT_W-1:0] StatusIdx = CNT_W'(STATUS_IDX);
	localparam logic [CNT_W-1:0] DistFirst = CNT_W'(DIST_FIRST);
	localparam logic [CNT_W-1:0] DistLast  = CNT_W'(DIST_LAST);

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [7:0]        xor_q, xor_d;
	logic              fault_q, fault_d;
	logic [31:0]       dist_q, dist_d;
	logic              in_body;
	logic              check_ok;

	assign in_body  = (cnt_q < CheckIdx);
	assign check_ok = (rx_byte == xor_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (byte_en) begin
			unique case (phase_q)
				PH_FIRST:  phase_d = (rx_byte == cfg.first_header) ? PH_SECOND : PH_FIRST;
				PH_SECOND: phase_d = (rx_byte == cfg.second_header) ? PH_BODY : PH_FIRST;
				PH_BODY:   phase_d = in_body ? PH_BODY : PH_FIRST;
				default:   phase_d = (rx_byte == cfg.first_header) ? PH_SECOND : PH_FIRST;
			endcase
		end
	end

	// count, xor, captured fields and result
	always_comb begin
		cnt_d          = cnt_q;
		xor_d          = xor_q;
		fault_d        = fault_q;
		dist_d         = dist_q;
		result.valid   = 1'b0;
		result.distance_value = dist_q;
		result.fault_flag     = fault_q;
		if (byte_en) begin
			unique case (phase_q)
				PH_SECOND: begin
					if (rx_byte == cfg.second_header) begin
						cnt_d = CNT_W'(2);
						xor_d = xor_q ^ rx_byte;
					end else begin
						cnt_d = '0;
						xor_d = '0;
					end
				end
				PH_BODY: begin
					if (in_body) begin
						if (cnt_q == StatusIdx) begin
							fault_d = rx_byte[7];
						end else if (cnt_q >= DistFirst && cnt_q <= DistLast) begin
							dist_d = {dist_q[23:0], rx_byte};
						end
						xor_d = xor_q ^ rx_byte;
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						result.valid = check_ok;
						cnt_d        = '0;
						xor_d        = '0;
					end
				end
				default: begin
					if (rx_byte == cfg.first_header) begin
						cnt_d   = CNT_W'(1);
						xor_d   = rx_byte;
						fault_d = 1'b0;
						dist_d  = '0;
					end else begin
						cnt_d = '0;
						xor_d = '0;
					end
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			cnt_q   <= '0;
			xor_q   <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			xor_q   <= xor_d;
		end
	end

	// captured frame fields
	always_ff @(posedge clk) begin
		fault_q <= fault_d;
		dist_q  <= dist_d;
	end

endmodule

`default_nettype wire

/* rtl/rff_out_stage.sv */
// result register in front of the master-side stream
`default_nettype none

module rff_out_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rff_pkg::rff_result_t result,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [31:0]               m_tdata,
	output logic                      m_tuser,
	output logic                      slot_free
);
	import rff_pkg::*;

	logic        valid_q;
	logic [31:0] dist_q;
	logic        fault_q;

	assign slot_free = ~valid_q | m_tready;

	// valid flag: set by a new result, cleared by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= result.valid | (valid_q & ~m_tready);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (result.valid) begin
			dist_q  <= result.distance_value;
			fault_q <= result.fault_flag;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = dist_q;
	assign m_tuser  = fault_q;

endmodule

`default_nettype wire

/* rtl/rangefinder_frame_receiver.sv */
// top level of the rangefinder frame receiver
`default_nettype none

// Takes one serial byte per transfer on the slave side and accepts a byte in
// every cycle while the result register is empty or being emptied. Each byte
// is handled by the frame parser; a frame that passes its xor check produces
// one result on the master side in the cycle after its check byte, and the
// sustained rate is one byte per cycle, limited only by back-pressure on the
// result register. Header values are set through the apb port: first header
// at address 0, second at address 4 (bit 2 of paddr selects the register).

module rangefinder_frame_receiver #(
	parameter int FRAME_LEN = rff_pkg::FRAME_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// byte input
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
	// result output
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,   // [31:0] distance_value
	output logic                             m_tuser,   // [0] fault_flag
	// configuration
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rff_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);
	import rff_pkg::*;

	rff_cfg_t    cfg;
	rff_result_t result;
	logic        slot_free;
	logic        byte_en;

	// a byte moves when the result register can take what it may produce
	assign s_tready = slot_free;
	assign byte_en  = s_tvalid & s_tready;

	rff_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rff_parser #(
		.FRAME_LEN (FRAME_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (s_tdata),
		.cfg     (cfg),
		.result  (result)
	);

	rff_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.slot_free (slot_free)
	);

endmodule

`default_nettype wire

/* rtl/rff_checker.sv */
// port-level checks for the rangefinder frame receiver
`default_nettype none

module rff_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        pready
);

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// the byte side never stalls while the result register is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no pending result");

	// a fresh result always follows a byte transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !$past(m_tvalid && !m_tready) |-> $past(s_tvalid && s_tready))
		else $error("result without a preceding byte transfer");

	// configuration port never waits
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind rangefinder_frame_receiver rff_checker u_rff_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

`default_nettype wire

/* tb/sv/rangefinder_frame_receiver_test.sv */
// self-checking testbench for the rangefinder frame receiver
`default_nettype none

module rangefinder_frame_receiver_test;
	import rff_pkg::*;

	localparam int FRAME_LEN  = FRAME_LEN_DEF;
	localparam int IDLE_LIMIT = 2000;

	// one decoded frame as seen on the master side
	typedef struct packed {
		logic [31:0] distance;
		logic        fault;
	} frame_result_t;

	// frame parser prediction and result comparison
	class frame_scoreboard;
		logic [7:0]    first_hdr;
		logic [7:0]    second_hdr;
		phase_t        hunt;
		logic [4:0]    count;
		logic [7:0]    xor_acc;
		logic [7:0]    status;
		logic [31:0]   dist_acc;
		frame_result_t frames_due[$];
		int unsigned   fails;

		function new();
			first_hdr  = FIRST_HEADER_RST;
			second_hdr = SECOND_HEADER_RST;
			status     = 8'h00;
			dist_acc   = 32'h0;
			fails      = 0;
			restart();
		endfunction

		function void restart();
			hunt    = PH_FIRST;
			count   = 5'd0;
			xor_acc = 8'h00;
		endfunction

		function int pending();
			return frames_due.size();
		endfunction

		function void fail(string msg);
			fails++;
			if (fails <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void set_header(logic idx, logic [7:0] value);
			if (idx == REG_FIRST_HEADER)
				first_hdr = value;
			else
				second_hdr = value;
		endfunction

		function void check_header(logic idx, logic [31:0] got);
			logic [31:0] want;
			want = {24'h0, (idx == REG_FIRST_HEADER) ? first_hdr : second_hdr};
			if (got !== want)
				fail($sformatf("register %0d read expected %h got %h", idx, want, got));
		endfunction

		// one accepted byte through the hunt / body / check sequence
		function void note_byte(logic [7:0] b);
			frame_result_t res;
			case (hunt)
				PH_SECOND: begin
					if (b == second_hdr) begin
						xor_acc ^= b;
						count = 5'd2;
						hunt  = PH_BODY;
					end else begin
						restart();
					end
				end
				PH_BODY: begin
					if (count < FRAME_LEN - 1) begin
						if (count == STATUS_IDX)
							status = b;
						else if (count >= DIST_FIRST && count <= DIST_LAST)
							dist_acc = {dist_acc[23:0], b};
						xor_acc ^= b;
						count++;
					end else begin
						if (b == xor_acc) begin
							res.distance = dist_acc;
							res.fault    = status[7];
							frames_due.push_back(res);
						end
						restart();
					end
				end
				default: begin
					if (b == first_hdr) begin
						xor_acc  = b;
						count    = 5'd1;
						status   = 8'h00;
						dist_acc = 32'h0;
						hunt     = PH_SECOND;
					end else begin
						restart();
					end
				end
			endcase
		endfunction

		function void check_result(logic [31:0] distance, logic fault);
			frame_result_t want;
			if (frames_due.size() == 0) begin
				fail($sformatf("result %h/%b with no frame pending", distance, fault));
				return;
			end
			want = frames_due.pop_front();
			if (distance !== want.distance)
				fail($sformatf("distance expected %h got %h", want.distance, distance));
			if (fault !== want.fault)
				fail($sformatf("fault flag expected %b got %b", want.fault, fault));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_scoreboard sb;
	logic [7:0]      rx_stream[$];
	bit              no_gaps;

	rangefinder_frame_receiver #(
		.FRAME_LEN(FRAME_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// mostly no gap, some short ones, a few long stalls
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] pick_distance();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// queue a frame, or only its first 'keep' bytes
	function automatic void push_frame(logic [7:0] status, logic [31:0] distance,
		bit bad_check, int keep);
		logic [7:0] bytes[FRAME_LEN];
		logic [7:0] chk;
		bytes[0] = sb.first_hdr;
		bytes[1] = sb.second_hdr;
		bytes[STATUS_IDX] = status;
		for (int i = DIST_FIRST; i <= DIST_LAST; i++)
			bytes[i] = distance[8*(DIST_LAST-i) +: 8];
		for (int i = DIST_LAST + 1; i < FRAME_LEN - 1; i++)
			bytes[i] = 8'($urandom());
		chk = 8'h00;
		for (int i = 0; i < FRAME_LEN - 1; i++)
			chk ^= bytes[i];
		bytes[FRAME_LEN-1] = bad_check ? chk ^ (8'h01 << $urandom_range(0, 7)) : chk;
		for (int i = 0; i < keep; i++)
			rx_stream.push_back(bytes[i]);
	endfunction

	// mostly well-formed frames, some broken ones and some line noise
	function automatic void fill_random(int n_bytes);
		int r;
		while (rx_stream.size() < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				push_frame(8'($urandom()), pick_distance(), $urandom_range(0, 4) == 0,
					FRAME_LEN);
			end else if (r < 84) begin
				push_frame(8'($urandom()), pick_distance(), 1'b0,
					$urandom_range(1, FRAME_LEN - 1));
			end else begin
				repeat ($urandom_range(1, 4))
					rx_stream.push_back(($urandom_range(0, 2) == 0) ? sb.first_hdr : 8'($urandom()));
			end
		end
	endfunction

	// slave side: one transfer per queued byte
	task automatic send_stream();
		int gap;
		logic [7:0] b;
		while (rx_stream.size() != 0) begin
			b = rx_stream.pop_front();
			gap = pick_gap();
			if (gap != 0) begin
				s_tvalid = 1'b0;
				s_tdata  = 8'($urandom());
				repeat (gap) @(negedge clk);
			end
			s_tvalid = 1'b1;
			s_tdata  = b;
			do @(posedge clk); while (!s_tready);
			@(negedge clk);
		end
		s_tvalid = 1'b0;
	endtask

	task automatic reg_read(input logic idx);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.check_header(idx, prdata);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// write then read back; upper data bits are junk and must be ignored
	task automatic reg_write(input logic idx, input logic [7:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {24'($urandom()), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_header(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		reg_read(idx);
	endtask

	// wait for every due frame, then let the parser drain
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic run_phase(logic [7:0] hdr_a, logic [7:0] hdr_b, bit quiet);
		settle();
		reg_write(REG_FIRST_HEADER, hdr_a);
		reg_write(REG_SECOND_HEADER, hdr_b);
		no_gaps = quiet;
		fill_random(250);
		send_stream();
	endtask

	// monitors for both streams
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_byte(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// master side back-pressure
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			m_tready = 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
			gap = pick_gap();
			if (gap != 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [7:0] same_hdr;
		sb       = new();
		no_gaps  = 1'b0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = 32'h0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset values of both headers
		reg_read(REG_FIRST_HEADER);
		reg_read(REG_SECOND_HEADER);

		// directed: zero and all-ones frames, a repeated first header, a bad check byte
		push_frame(8'h00, 32'h0000_0000, 1'b0, FRAME_LEN);
		push_frame(8'hff, 32'hffff_ffff, 1'b0, FRAME_LEN);
		rx_stream.push_back(sb.first_hdr);
		rx_stream.push_back(sb.first_hdr);
		push_frame(8'h80, 32'h1234_5678, 1'b1, FRAME_LEN);
		send_stream();

		// random traffic at the reset headers
		fill_random(250);
		send_stream();

		// header extremes, equal headers, then random headers
		run_phase(8'h00, 8'hff, 1'b1);
		run_phase(8'hff, 8'h00, 1'b0);
		same_hdr = 8'($urandom());
		run_phase(same_hdr, same_hdr, 1'b0);
		run_phase(8'($urandom()), 8'($urandom()), 1'b0);

		settle();
		repeat (4) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
